@@ src/mrr_pkg.sv @@
// Shared types and constants of the Modbus register responder.
package mrr_pkg;

    localparam int REG_COUNT_DEFAULT = 64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_CODE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_CODE    = 2'd2;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
    localparam logic [7:0] READ_CODE_RESET     = 8'd3;
    localparam logic [7:0] WRITE_CODE_RESET    = 8'd6;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Frame byte positions, in transmit order
    localparam logic [2:0] BYTE_ADDRESS  = 3'd0;
    localparam logic [2:0] BYTE_CODE     = 3'd1;
    localparam logic [2:0] BYTE_INDEX_HI = 3'd2;
    localparam logic [2:0] BYTE_INDEX_LO = 3'd3;
    localparam logic [2:0] BYTE_VALUE_HI = 3'd4;
    localparam logic [2:0] BYTE_VALUE_LO = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI   = 3'd7;

    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [15:0] reg_index;
        logic [15:0] write_value;
        logic [15:0] max_value;
        logic [15:0] min_value;
    } req_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [15:0] reg_value;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_CRC,
        ST_SEND
    } state_t;

endpackage

@@ src/modbus_register_responder.sv @@
// Modbus single-register responder: register store, bit-serial CRC-16 and frame sender.
//
// Sequence: an answered request goes through the check, the store read and one bit step of the
// shared CRC shift unit per bit of the six leading bytes before m_valid rises with its first
// frame byte; the eight bytes then go out one per cycle while m_ready is high. A rejected
// request goes from the check straight back to idle, where the input is taken again.
// Reset: after aresetn the store is cleared, one entry per cycle, REG_COUNT cycles,
// before the first request is taken; configuration writes are taken throughout.
module modbus_register_responder
    import mrr_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  req_t                   s_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output rsp_t                   m_data,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    // Store address width; a one-entry store still gets one address bit
    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);
    localparam logic [IDX_W-1:0] CLEAR_LAST = IDX_W'(REG_COUNT - 1);

    state_t state_reg, state_next;

    // Configuration registers
    logic [7:0] slave_address_reg;
    logic [7:0] read_code_reg;
    logic [7:0] write_code_reg;

    // Request and datapath registers
    req_t        req_reg, req_next;
    logic [15:0] value_reg, value_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Register store
    logic [15:0] store [0:REG_COUNT-1];
    logic [15:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [15:0]       mem_wdata;

    // Request checks and clamp
    logic        in_range;
    logic        bounds_ok;
    logic        accept_req;
    logic [15:0] clamped;

    // Shared CRC bit-step unit
    logic [7:0]  cur_byte;
    logic [15:0] crc_operand;
    logic [15:0] crc_step;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
            read_code_reg     <= READ_CODE_RESET;
            write_code_reg    <= WRITE_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            // Drop writes to indexes beyond the register list
            if (cfg_index == CFG_SLAVE_ADDRESS) begin
                slave_address_reg <= cfg_data;
            end else if (cfg_index == CFG_READ_CODE) begin
                read_code_reg <= cfg_data;
            end else if (cfg_index == CFG_WRITE_CODE) begin
                write_code_reg <= cfg_data;
            end
        end
    end

    // Reject an index outside the store, and a write with max below min
    assign in_range   = ({1'b0, req_reg.reg_index} < REG_LIMIT);
    assign bounds_ok  = (req_reg.kind == KIND_READ) || (req_reg.max_value >= req_reg.min_value);
    assign accept_req = in_range && bounds_ok;

    always_comb begin
        if (req_reg.write_value > req_reg.max_value) begin
            clamped = req_reg.max_value;
        end else if (req_reg.write_value < req_reg.min_value) begin
            clamped = req_reg.min_value;
        end else begin
            clamped = req_reg.write_value;
        end
    end

    // Frame byte selected by the byte counter; feeds both the CRC unit and the output
    always_comb begin
        unique case (byte_cnt_reg)
            BYTE_ADDRESS:  cur_byte = slave_address_reg;
            BYTE_CODE:     cur_byte = (req_reg.kind == KIND_WRITE) ? write_code_reg
                                                                   : read_code_reg;
            BYTE_INDEX_HI: cur_byte = req_reg.reg_index[15:8];
            BYTE_INDEX_LO: cur_byte = req_reg.reg_index[7:0];
            BYTE_VALUE_HI: cur_byte = value_reg[15:8];
            BYTE_VALUE_LO: cur_byte = value_reg[7:0];
            BYTE_CRC_LO:   cur_byte = crc_reg[7:0];
            BYTE_CRC_HI:   cur_byte = crc_reg[15:8];
            default:       cur_byte = '0;
        endcase
    end

    // One CRC-16/Modbus bit step per cycle; fold the byte in on its first bit
    assign crc_operand = (bit_cnt_reg == '0) ? (crc_reg ^ {8'h00, cur_byte}) : crc_reg;
    assign crc_step    = crc_operand[0] ? ((crc_operand >> 1) ^ CRC_POLY) : (crc_operand >> 1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = accept_req ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                state_next = ST_CRC;
            end
            ST_CRC: begin
                if (bit_cnt_reg == BIT_LAST && byte_cnt_reg == BYTE_VALUE_LO) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_ready && byte_cnt_reg == BYTE_CRC_HI) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        req_next      = req_reg;
        value_next    = value_reg;
        crc_next      = crc_reg;
        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        clr_cnt_next  = clr_cnt_reg;
        mem_we        = 1'b0;
        mem_addr      = req_reg.reg_index[IDX_W-1:0];
        mem_wdata     = clamped;

        unique case (state_reg)
            ST_CLEAR: begin
                // Zero one store entry per cycle
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_data;
                end
            end
            ST_CHECK: begin
                // Store the clamped value on a write; the read path fetches the entry
                mem_we     = accept_req && (req_reg.kind == KIND_WRITE);
                value_next = clamped;
            end
            ST_LOAD: begin
                if (req_reg.kind == KIND_READ) begin
                    value_next = rd_data_reg;
                end
                crc_next      = CRC_INIT;
                byte_cnt_next = BYTE_ADDRESS;
                bit_cnt_next  = '0;
            end
            ST_CRC: begin
                crc_next     = crc_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST) begin
                    byte_cnt_next = (byte_cnt_reg == BYTE_VALUE_LO) ? BYTE_ADDRESS
                                                                    : byte_cnt_reg + 1'b1;
                end
            end
            ST_SEND: begin
                m_valid = 1'b1;
                // Advance one byte per transfer, hold while stalled
                if (m_ready) begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_data.frame_byte = cur_byte;
    assign m_data.last_byte  = (byte_cnt_reg == BYTE_CRC_HI);
    assign m_data.reg_value  = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            byte_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            clr_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        value_reg <= value_next;
        crc_reg   <= crc_next;
    end

    // Single-port store with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= store[mem_addr];
    end

endmodule
